// ===== rtl/frwl_pkg.sv =====
// Shared types and constants for the fair reader-writer lock arbiter.
package frwl_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 3;

    // Holder accounting
    localparam int HOLDER_W   = 5;
    localparam int HOLDER_MAX = 31;
    localparam int MAX_GRANTS = 16;
    localparam int GRANT_W    = $clog2(MAX_GRANTS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_FREE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_UNLOCKED = 2'd0,
        MODE_READ     = 2'd1,
        MODE_WRITE    = 2'd2
    } mode_t;

    // Source of the id in an emitted word
    typedef enum logic [1:0] {
        SRC_ITEM = 2'd0,
        SRC_HEAD = 2'd1,
        SRC_PEND = 2'd2
    } id_src_t;

    // One waiting request
    typedef struct packed {
        logic            wr;
        logic [ID_W-1:0] id;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    grant_req;
        logic    enqueue;
        logic    release_dec;
        logic    unlock;
        logic    pop_writer;
        logic    pop_reader_first;
        logic    pop_reader_next;
        logic    emit;
        status_t status;
        id_src_t id_src;
        logic    wr;
        logic    last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic req_fits;
        logic q_empty;
        logic q_full;
        logic lock_free;
        logic holder_is_one;
        logic head_is_write;
        logic run_more;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/frwl_ctrl.sv =====
// Control state machine for the lock arbiter: sequences decisions and reader runs.
module frwl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  frwl_pkg::sts_t sts,
    output frwl_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT_HEAD,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_write;

    assign in_ready = (state_reg == S_IDLE);
    assign is_write = (sts.op == frwl_pkg::OP_WRITE);

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    frwl_pkg::OP_READ, frwl_pkg::OP_WRITE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.id_src = frwl_pkg::SRC_ITEM;
                            cmd.last   = 1'b1;
                            if (sts.q_empty && sts.req_fits)
                            begin
                                cmd.grant_req = 1'b1;
                                cmd.status    = frwl_pkg::ST_GRANTED;
                                cmd.wr        = is_write;
                            end
                            else if (sts.q_full)
                            begin
                                cmd.status = frwl_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.enqueue = 1'b1;
                                cmd.status  = frwl_pkg::ST_QUEUED;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    frwl_pkg::OP_RELEASE:
                    begin
                        if (sts.out_free)
                        begin
                            state_next = S_IDLE;
                            if (sts.lock_free)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = frwl_pkg::ST_FREE;
                                cmd.id_src = frwl_pkg::SRC_ITEM;
                                cmd.last   = 1'b1;
                            end
                            else if (!sts.holder_is_one || sts.q_empty)
                            begin
                                cmd.release_dec = 1'b1;
                                cmd.unlock      = sts.holder_is_one;
                                cmd.emit        = 1'b1;
                                cmd.status      = frwl_pkg::ST_RELEASED;
                                cmd.id_src      = frwl_pkg::SRC_ITEM;
                                cmd.last        = 1'b1;
                            end
                            else if (sts.head_is_write)
                            begin
                                cmd.pop_writer = 1'b1;
                                cmd.emit       = 1'b1;
                                cmd.status     = frwl_pkg::ST_GRANTED;
                                cmd.id_src     = frwl_pkg::SRC_HEAD;
                                cmd.wr         = 1'b1;
                                cmd.last       = 1'b1;
                            end
                            else
                            begin
                                // first reader is held back until last is known
                                cmd.pop_reader_first = 1'b1;
                                state_next           = S_WAIT_HEAD;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WAIT_HEAD:
            begin
                // queue read port catches up with the new head
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = frwl_pkg::ST_GRANTED;
                    cmd.id_src = frwl_pkg::SRC_PEND;
                    if (sts.run_more)
                    begin
                        cmd.pop_reader_next = 1'b1;
                        state_next          = S_WAIT_HEAD;
                    end
                    else
                    begin
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/frwl_dp.sv =====
// Datapath for the lock arbiter: lock state, waiting queue and output word register.
module frwl_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [frwl_pkg::OP_W-1:0]     operation,
    input  logic [frwl_pkg::ID_W-1:0]     requester_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [frwl_pkg::STATUS_W-1:0] status,
    output logic [frwl_pkg::ID_W-1:0]     grant_id,
    output logic                          grant_is_write,
    output logic                          last,
    input  frwl_pkg::cmd_t                cmd,
    output frwl_pkg::sts_t                sts
);

    localparam logic [frwl_pkg::QCNT_W-1:0] QFULL =
        frwl_pkg::QCNT_W'(frwl_pkg::QUEUE_DEPTH);
    localparam logic [frwl_pkg::QPTR_W-1:0] QLAST =
        frwl_pkg::QPTR_W'(frwl_pkg::QUEUE_DEPTH - 1);
    localparam logic [frwl_pkg::HOLDER_W-1:0] HMAX =
        frwl_pkg::HOLDER_W'(frwl_pkg::HOLDER_MAX);
    localparam logic [frwl_pkg::GRANT_W-1:0] GMAX =
        frwl_pkg::GRANT_W'(frwl_pkg::MAX_GRANTS);

    // Waiting queue storage
    frwl_pkg::entry_t queue_mem [frwl_pkg::QUEUE_DEPTH];
    frwl_pkg::entry_t rd_data_reg;

    // Item and lock state
    frwl_pkg::op_t                op_reg;
    logic [frwl_pkg::ID_W-1:0]     id_reg;
    frwl_pkg::mode_t              mode_reg;
    frwl_pkg::mode_t              mode_next;
    logic [frwl_pkg::HOLDER_W-1:0] holder_reg;
    logic [frwl_pkg::HOLDER_W-1:0] holder_next;
    logic [frwl_pkg::QPTR_W-1:0]   head_reg;
    logic [frwl_pkg::QPTR_W-1:0]   tail_reg;
    logic [frwl_pkg::QCNT_W-1:0]   count_reg;
    logic [frwl_pkg::GRANT_W-1:0]  grants_reg;
    logic [frwl_pkg::ID_W-1:0]     pend_id_reg;

    // Output word register
    logic                          out_valid_reg;
    frwl_pkg::status_t             status_reg;
    logic [frwl_pkg::ID_W-1:0]     grant_id_reg;
    logic                          grant_is_write_reg;
    logic                          last_reg;
    logic [frwl_pkg::ID_W-1:0]     emit_id;

    logic pop;
    logic req_is_write;

    assign pop          = cmd.pop_writer | cmd.pop_reader_first | cmd.pop_reader_next;
    assign req_is_write = (op_reg == frwl_pkg::OP_WRITE);

    // Status to the controller
    always_comb
    begin
        sts.op            = op_reg;
        sts.req_fits      = req_is_write ? (mode_reg == frwl_pkg::MODE_UNLOCKED)
                          : ((mode_reg == frwl_pkg::MODE_UNLOCKED) ||
                             (mode_reg == frwl_pkg::MODE_READ && holder_reg < HMAX));
        sts.q_empty       = (count_reg == '0);
        sts.q_full        = (count_reg >= QFULL);
        sts.lock_free     = (mode_reg == frwl_pkg::MODE_UNLOCKED) || (holder_reg == '0);
        sts.holder_is_one = (holder_reg == frwl_pkg::HOLDER_W'(1));
        sts.head_is_write = rd_data_reg.wr;
        sts.run_more      = (count_reg != '0) && (grants_reg < GMAX) &&
                            (holder_reg < HMAX) && !rd_data_reg.wr;
        sts.out_free      = !out_valid_reg || out_ready;
    end

    // Lock mode and holder count updates
    always_comb
    begin
        mode_next   = mode_reg;
        holder_next = holder_reg;
        if (cmd.grant_req)
        begin
            mode_next   = req_is_write ? frwl_pkg::MODE_WRITE : frwl_pkg::MODE_READ;
            holder_next = req_is_write ? frwl_pkg::HOLDER_W'(1)
                                       : holder_reg + frwl_pkg::HOLDER_W'(1);
        end
        else if (cmd.release_dec)
        begin
            holder_next = holder_reg - frwl_pkg::HOLDER_W'(1);
            if (cmd.unlock)
            begin
                mode_next = frwl_pkg::MODE_UNLOCKED;
            end
        end
        else if (cmd.pop_writer)
        begin
            mode_next   = frwl_pkg::MODE_WRITE;
            holder_next = frwl_pkg::HOLDER_W'(1);
        end
        else if (cmd.pop_reader_first)
        begin
            mode_next   = frwl_pkg::MODE_READ;
            holder_next = frwl_pkg::HOLDER_W'(1);
        end
        else if (cmd.pop_reader_next)
        begin
            holder_next = holder_reg + frwl_pkg::HOLDER_W'(1);
        end
    end

    // Id for the emitted word
    always_comb
    begin
        case (cmd.id_src)
            frwl_pkg::SRC_HEAD: emit_id = rd_data_reg.id;
            frwl_pkg::SRC_PEND: emit_id = pend_id_reg;
            default:            emit_id = id_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= frwl_pkg::MODE_UNLOCKED;
            holder_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            grants_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            holder_reg <= holder_next;
            if (cmd.enqueue)
            begin
                tail_reg  <= (tail_reg == QLAST) ? '0 : tail_reg + frwl_pkg::QPTR_W'(1);
                count_reg <= count_reg + frwl_pkg::QCNT_W'(1);
            end
            else if (pop)
            begin
                head_reg  <= (head_reg == QLAST) ? '0 : head_reg + frwl_pkg::QPTR_W'(1);
                count_reg <= count_reg - frwl_pkg::QCNT_W'(1);
            end
            if (cmd.pop_reader_first)
            begin
                grants_reg <= frwl_pkg::GRANT_W'(1);
            end
            else if (cmd.pop_reader_next)
            begin
                grants_reg <= grants_reg + frwl_pkg::GRANT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= frwl_pkg::op_t'(operation);
            id_reg <= requester_id;
        end
        if (cmd.pop_reader_first || cmd.pop_reader_next)
        begin
            pend_id_reg <= rd_data_reg.id;
        end
        if (cmd.emit)
        begin
            status_reg         <= cmd.status;
            grant_id_reg       <= emit_id;
            grant_is_write_reg <= cmd.wr;
            last_reg           <= cmd.last;
        end
    end

    // Queue memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (cmd.enqueue)
        begin
            queue_mem[tail_reg] <= {req_is_write, id_reg};
        end
        rd_data_reg <= queue_mem[head_reg];
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign grant_id       = grant_id_reg;
    assign grant_is_write = grant_is_write_reg;
    assign last           = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QFULL)
        else $error("queue count exceeds depth");

    a_unlocked_no_holder: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == frwl_pkg::MODE_UNLOCKED) |-> (holder_reg == '0))
        else $error("unlocked with holders");

    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == frwl_pkg::MODE_WRITE) |-> (holder_reg == frwl_pkg::HOLDER_W'(1)))
        else $error("write lock with holder count other than one");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enqueue |-> (count_reg != QFULL))
        else $error("enqueue into full queue");

endmodule

// ===== rtl/fair_reader_writer_lock_arbiter.sv =====
// Top level of the FIFO-fair reader-writer lock arbiter.
// A result word is registered into the output word register once that register is free;
// the first grant of a woken reader run first passes through the queue read register.
// An input word is taken only in the idle state, after the words of the last one are
// emitted; a release that wakes a run of readers emits their grants one at a time.
// Reset: rst_n asynchronous, clears lock state, queue pointers, counts and output valid only.
module fair_reader_writer_lock_arbiter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [frwl_pkg::OP_W-1:0]     operation,
    input  logic [frwl_pkg::ID_W-1:0]     requester_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [frwl_pkg::STATUS_W-1:0] status,
    output logic [frwl_pkg::ID_W-1:0]     grant_id,
    output logic                          grant_is_write,
    output logic                          last
);

    frwl_pkg::cmd_t cmd;
    frwl_pkg::sts_t sts;

    // Controller
    frwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    frwl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .operation      (operation),
        .requester_id   (requester_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .grant_id       (grant_id),
        .grant_is_write (grant_is_write),
        .last           (last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the fair reader-writer lock arbiter.
module tb;

    // Stimulus sizing and run limits
    localparam int ITEM_TARGET = 410;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT     = 150;

    // Operation code the block ignores
    localparam logic [frwl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Random traffic profiles
    localparam int PROF_MIXED       = 0;
    localparam int PROF_READ_FLOOD  = 1;
    localparam int PROF_WRITE_HEAVY = 2;
    localparam int PROF_DRAIN       = 3;

    // One result word as the block presents it
    typedef struct packed {
        frwl_pkg::status_t         status;
        logic [frwl_pkg::ID_W-1:0] id;
        logic                      wr;
        logic                      last;
    } word_t;

    // One row of the directed script
    typedef struct packed {
        logic [frwl_pkg::OP_W-1:0] op;
        logic [frwl_pkg::ID_W-1:0] id;
        logic                      typed;
        word_t                     want;
    } script_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [frwl_pkg::OP_W-1:0]     operation;
    logic [frwl_pkg::ID_W-1:0]     requester_id;
    logic                          out_valid;
    logic                          out_ready;
    logic [frwl_pkg::STATUS_W-1:0] status;
    logic [frwl_pkg::ID_W-1:0]     grant_id;
    logic                          grant_is_write;
    logic                          last;

    // Lock state as the testbench sees it
    frwl_pkg::mode_t               lock_state;
    logic [frwl_pkg::HOLDER_W-1:0] holder_cnt;
    frwl_pkg::entry_t              waiters[$];

    word_t       step_words[$];
    word_t       due_words[$];
    script_row_t script[$];
    word_t       no_word;
    word_t       want;

    int mismatches;
    int words_seen;
    int quiet_cycles;
    int requests_done;
    bit hold_done;

    fair_reader_writer_lock_arbiter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .requester_id   (requester_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .grant_id       (grant_id),
        .grant_is_write (grant_is_write),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(string what, int got, int exp_val);
        mismatches++;
        $display("tb: mismatch on %s at word %0d: got %0d, want %0d",
                 what, words_seen, got, exp_val);
    endtask

    function automatic void emit_word(frwl_pkg::status_t st,
                                      logic [frwl_pkg::ID_W-1:0] id, logic wr,
                                      logic lst);
        word_t w;
        w.status = st;
        w.id     = id;
        w.wr     = wr;
        w.last   = lst;
        step_words.push_back(w);
    endfunction

    // Lock arbitration for one accepted word; fills step_words
    function automatic void lock_decide(logic [frwl_pkg::OP_W-1:0] op,
                                        logic [frwl_pkg::ID_W-1:0] id);
        logic             is_wr;
        logic             fits;
        frwl_pkg::entry_t e;
        int               n;
        int               k;
        step_words.delete();
        is_wr = (op == frwl_pkg::OP_WRITE);
        if (op == frwl_pkg::OP_READ || op == frwl_pkg::OP_WRITE)
        begin
            if (is_wr)
                fits = (lock_state == frwl_pkg::MODE_UNLOCKED);
            else
                fits = (lock_state == frwl_pkg::MODE_UNLOCKED) ||
                       (lock_state == frwl_pkg::MODE_READ &&
                        holder_cnt < frwl_pkg::HOLDER_MAX);
            if (waiters.size() == 0 && fits)
            begin
                if (is_wr)
                begin
                    lock_state = frwl_pkg::MODE_WRITE;
                    holder_cnt = frwl_pkg::HOLDER_W'(1);
                end
                else
                begin
                    lock_state = frwl_pkg::MODE_READ;
                    holder_cnt = holder_cnt + frwl_pkg::HOLDER_W'(1);
                end
                emit_word(frwl_pkg::ST_GRANTED, id, is_wr, 1'b1);
            end
            else if (waiters.size() >= frwl_pkg::QUEUE_DEPTH)
                emit_word(frwl_pkg::ST_FULL, id, 1'b0, 1'b1);
            else
            begin
                e.wr = is_wr;
                e.id = id;
                waiters.push_back(e);
                emit_word(frwl_pkg::ST_QUEUED, id, 1'b0, 1'b1);
            end
        end
        else if (op == frwl_pkg::OP_RELEASE)
        begin
            if (lock_state == frwl_pkg::MODE_UNLOCKED || holder_cnt == 0)
                emit_word(frwl_pkg::ST_FREE, id, 1'b0, 1'b1);
            else
            begin
                holder_cnt = holder_cnt - frwl_pkg::HOLDER_W'(1);
                if (holder_cnt != 0)
                    emit_word(frwl_pkg::ST_RELEASED, id, 1'b0, 1'b1);
                else if (waiters.size() == 0)
                begin
                    lock_state = frwl_pkg::MODE_UNLOCKED;
                    emit_word(frwl_pkg::ST_RELEASED, id, 1'b0, 1'b1);
                end
                else if (waiters[0].wr)
                begin
                    e = waiters.pop_front();
                    lock_state = frwl_pkg::MODE_WRITE;
                    holder_cnt = frwl_pkg::HOLDER_W'(1);
                    emit_word(frwl_pkg::ST_GRANTED, e.id, 1'b1, 1'b1);
                end
                else
                begin
                    // wake the run of readers at the head, capped by grants and holders
                    lock_state = frwl_pkg::MODE_READ;
                    n = 0;
                    while (n < waiters.size() && n < frwl_pkg::MAX_GRANTS &&
                           holder_cnt + n < frwl_pkg::HOLDER_MAX && !waiters[n].wr)
                        n++;
                    for (k = 0; k < n; k++)
                    begin
                        e = waiters.pop_front();
                        holder_cnt = holder_cnt + frwl_pkg::HOLDER_W'(1);
                        emit_word(frwl_pkg::ST_GRANTED, e.id, 1'b0, k == n - 1);
                    end
                end
            end
        end
    endfunction

    // Present one word, wait for acceptance, then queue what it must cause
    task automatic offer(logic [frwl_pkg::OP_W-1:0] op, logic [frwl_pkg::ID_W-1:0] id,
                         logic typed, word_t typed_word);
        int j;
        @(negedge clk);
        in_valid     <= 1'b1;
        operation    <= op;
        requester_id <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lock_decide(op, id);
        if (typed)
            due_words.push_back(typed_word);
        else
            for (j = 0; j < step_words.size(); j++)
                due_words.push_back(step_words[j]);
        if (op != OP_UNUSED)
            requests_done++;
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        in_valid     <= 1'b0;
        operation    <= frwl_pkg::OP_W'($urandom);
        requester_id <= frwl_pkg::ID_W'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stop sending until every due word has come back
    task automatic settle(int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic script_row(logic [frwl_pkg::OP_W-1:0] op,
                              logic [frwl_pkg::ID_W-1:0] id, logic typed,
                              frwl_pkg::status_t st, logic [frwl_pkg::ID_W-1:0] gid,
                              logic wr);
        script_row_t r;
        r.op          = op;
        r.id          = id;
        r.typed       = typed;
        r.want.status = st;
        r.want.id     = gid;
        r.want.wr     = wr;
        r.want.last   = 1'b1;
        script.push_back(r);
    endtask

    function automatic logic [frwl_pkg::OP_W-1:0] pick_op(int profile);
        int r;
        int rd_pct;
        int wr_pct;
        r = $urandom_range(0, 99);
        case (profile)
            PROF_READ_FLOOD:  begin rd_pct = 90; wr_pct = 5;  end
            PROF_WRITE_HEAVY: begin rd_pct = 20; wr_pct = 45; end
            PROF_DRAIN:       begin rd_pct = 15; wr_pct = 10; end
            default:          begin rd_pct = 40; wr_pct = 20; end
        endcase
        if (r < 3)
            return OP_UNUSED;
        r = $urandom_range(0, 99);
        if (r < rd_pct)
            return frwl_pkg::OP_READ;
        if (r < rd_pct + wr_pct)
            return frwl_pkg::OP_WRITE;
        return frwl_pkg::OP_RELEASE;
    endfunction

    // Output checker and activity count for the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (due_words.size() == 0)
                    flag_mismatch("word with nothing due, status", status, -1);
                else
                begin
                    want = due_words.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", status, want.status);
                    if (grant_id !== want.id)
                        flag_mismatch("grant_id", grant_id, want.id);
                    if (grant_is_write !== want.wr)
                        flag_mismatch("grant_is_write", grant_is_write, want.wr);
                    if (last !== want.last)
                        flag_mismatch("last", last, want.last);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb: errors");
        $finish;
    end

    // Receiver: stretches of stall patterns, plus one long hold-off
    initial
    begin : receiver
        int mode;
        int span;
        int k;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && requests_done >= HOLD_AT)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= (k % 4 == 3);
                    default: out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Sender: reset, directed script, then random phases
    initial
    begin : sender
        int phase;
        int profile;
        int span;
        int k;
        int burst_left;
        int gap;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = frwl_pkg::OP_READ;
        requester_id  = '0;
        no_word       = '0;
        mismatches    = 0;
        words_seen    = 0;
        quiet_cycles  = 0;
        requests_done = 0;
        hold_done     = 1'b0;
        lock_state    = frwl_pkg::MODE_UNLOCKED;
        holder_cnt    = '0;

        // free lock, reads sharing, writer and readers queued behind, wake paths
        script_row(frwl_pkg::OP_RELEASE, 4'd0,  1'b1, frwl_pkg::ST_FREE,     4'd0,  1'b0);
        script_row(OP_UNUSED,            4'd15, 1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_READ,    4'd15, 1'b1, frwl_pkg::ST_GRANTED,  4'd15, 1'b0);
        script_row(frwl_pkg::OP_READ,    4'd0,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_WRITE,   4'd9,  1'b1, frwl_pkg::ST_QUEUED,   4'd9,  1'b0);
        script_row(frwl_pkg::OP_READ,    4'd6,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_READ,    4'd10, 1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd15, 1'b1, frwl_pkg::ST_RELEASED, 4'd15, 1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd3,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_WRITE,   4'd5,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd9,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd0,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd0,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd5,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd7,  1'b1, frwl_pkg::ST_FREE,     4'd7,  1'b0);
        script_row(frwl_pkg::OP_WRITE,   4'd15, 1'b1, frwl_pkg::ST_GRANTED,  4'd15, 1'b1);
        script_row(frwl_pkg::OP_READ,    4'd0,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(OP_UNUSED,            4'd0,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd15, 1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);
        script_row(frwl_pkg::OP_RELEASE, 4'd0,  1'b0, frwl_pkg::ST_GRANTED,  4'd0,  1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            offer(script[i].op, script[i].id, script[i].typed, script[i].want);

        // first a reader flood to reach the holder cap and a full queue, then a drain
        phase = 0;
        burst_left = 0;
        while (requests_done < ITEM_TARGET)
        begin
            if (phase == 0)
                profile = PROF_READ_FLOOD;
            else if (phase == 1)
                profile = PROF_DRAIN;
            else
                profile = $urandom_range(0, 3);
            span = (phase < 2) ? 70 : $urandom_range(15, 60);
            for (k = 0; k < span && requests_done < ITEM_TARGET; k++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    if (gap != 0)
                        pause_sender(gap);
                end
                burst_left--;
                offer(pick_op(profile), frwl_pkg::ID_W'($urandom_range(0, 15)), 1'b0,
                      no_word);
            end
            phase++;
            // no drain while the receiver's long hold-off is pending
            if (phase == 1 ||
                ($urandom_range(0, 3) == 0 && (hold_done || requests_done < 100)))
                settle(4);
        end

        settle(8);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/frwl_pkg.sv
rtl/frwl_ctrl.sv
rtl/frwl_dp.sv
rtl/fair_reader_writer_lock_arbiter.sv
tb/sv/tb.sv
